// ===== hw/rtl/tta_pkg.sv =====
// Shared types and constants for the temperature trend alarm.
// Field widths, register reset values, register indexes and result codes.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package tta_pkg;

	localparam int DEPTH_DEFAULT = 64;

	localparam int TIME_W     = 32;
	localparam int TEMP_W     = 12;
	localparam int RL_W       = 13;
	localparam int SEC_W      = 12;
	localparam int CLS_W      = 2;
	localparam int RATE_W     = 14;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	// Largest reported rate magnitude; the quotient register is sized to hold one past it.
	localparam int RATE_MAX = 8190;
	localparam int Q_W      = 13;

	localparam logic signed [TEMP_W-1:0] CRIT_RESET   = 12'sd432;
	localparam logic [RL_W-1:0]          RL_RESET     = 13'd48;
	localparam logic [SEC_W-1:0]         WINDOW_RESET = 12'd30;
	localparam logic [SEC_W-1:0]         IGNORE_RESET = 12'd10;

	localparam logic [CFG_IDX_W-1:0] REG_CRITICAL = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RISE     = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IGNORE   = 4'd3;

	localparam logic [CLS_W-1:0] CLS_NONE  = 2'd0;
	localparam logic [CLS_W-1:0] CLS_WARN  = 2'd1;
	localparam logic [CLS_W-1:0] CLS_ERROR = 2'd2;

	// Request from the control sequencer to the history ring.
	typedef struct packed {
		logic                     start;
		logic                     scan;
		logic [TIME_W-1:0]        now;
		logic signed [TEMP_W-1:0] temp;
	} hist_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tta_if.sv =====
// Channel interfaces of the temperature trend alarm: sample input, result output
// and configuration write. Each has a source and a sink modport.
// Depends on tta_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tta_sample_if import tta_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [TIME_W-1:0]        sample_time;
	logic signed [TEMP_W-1:0] sample_temp;

	modport source (output valid, output sample_time, output sample_temp, input ready);
	modport sink   (input valid, input sample_time, input sample_temp, output ready);
endinterface

interface tta_result_if import tta_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [CLS_W-1:0]         anomaly_class;
	logic signed [RATE_W-1:0] rise_rate;

	modport source (output valid, output anomaly_class, output rise_rate, input ready);
	modport sink   (input valid, input anomaly_class, input rise_rate, output ready);
endinterface

interface tta_cfg_if import tta_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/temperature_trend_alarm.sv =====
// Temperature trend alarm top level: configuration registers, item sequencer and
// result register around the history ring and the rise rate unit.
// Depends on tta_pkg, tta_if, tta_history and tta_rate.
//
// Usage: samples {sample_time, sample_temp} enter on the sample channel, one result
// {anomaly_class, rise_rate} leaves on the result channel for each sample, in order.
// The cfg channel is always ready; registers 0..3 are critical level, rise limit,
// window and ignore time, and are to be written only while no sample is in flight.
// A sample is taken only when the previous one has finished its computation.
// A sample over the critical level skips the ring scan and the rate unit; its result
// enters the result register once that is free. Otherwise the ring scan reads one
// entry a cycle through the memory's single read port, over every stored sample, and
// the rate unit then divides by restoring steps, one quotient bit each. The result
// register frees the next sample to enter while the result waits; if the receiver
// stalls, the following result is held until the register empties. Reset empties
// the ring and the result register and loads the default register values; the ring
// needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module temperature_trend_alarm import tta_pkg::*; #(
	parameter int HISTORY_DEPTH = DEPTH_DEFAULT
) (
	input wire logic     clk,
	input wire logic     arst_n,
	tta_cfg_if.sink      cfg,
	tta_sample_if.sink   sample,
	tta_result_if.source result
);

	localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
	localparam int SUM_W = TEMP_W + CNT_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_RATE,
		S_FINISH
	} seq_state_t;

	seq_state_t               state_q;
	logic signed [TEMP_W-1:0] crit_q;
	logic [RL_W-1:0]          rise_q;
	logic [SEC_W-1:0]         window_q;
	logic [SEC_W-1:0]         ignore_q;
	logic signed [TEMP_W-1:0] temp_q;
	logic [CLS_W-1:0]         pend_cls_q;
	logic signed [RATE_W-1:0] pend_rate_q;
	logic                     out_valid_q;
	logic [CLS_W-1:0]         out_cls_q;
	logic signed [RATE_W-1:0] out_rate_q;

	hist_req_t                hist_req;
	logic                     accept;
	logic                     over_crit;
	logic                     hist_done;
	logic signed [SUM_W-1:0]  hist_sum;
	logic [CNT_W-1:0]         hist_count;
	logic                     rate_start;
	logic                     rate_done;
	logic                     rate_warn;
	logic signed [RATE_W-1:0] rate_val;
	logic                     slot_free;

	assign cfg.ready    = 1'b1;
	assign sample.ready = (state_q == S_IDLE);
	assign accept       = sample.valid && sample.ready;
	assign over_crit    = sample.sample_temp > crit_q;
	assign rate_start   = (state_q == S_SCAN) && hist_done;
	assign slot_free    = !out_valid_q || result.ready;

	assign hist_req.start = accept;
	assign hist_req.scan  = !over_crit;
	assign hist_req.now   = sample.sample_time;
	assign hist_req.temp  = sample.sample_temp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crit_q   <= CRIT_RESET;
			rise_q   <= RL_RESET;
			window_q <= WINDOW_RESET;
			ignore_q <= IGNORE_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_CRITICAL: crit_q   <= $signed(cfg.data[TEMP_W-1:0]);
				REG_RISE:     rise_q   <= cfg.data[RL_W-1:0];
				REG_WINDOW:   window_q <= cfg.data[SEC_W-1:0];
				REG_IGNORE:   ignore_q <= cfg.data[SEC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			out_cls_q   <= CLS_NONE;
			out_rate_q  <= '0;
			pend_cls_q  <= CLS_NONE;
			pend_rate_q <= '0;
			temp_q      <= '0;
		end else begin
			// In the finishing state the result register is refilled below whenever
			// a transfer empties it.
			if (result.valid && result.ready && state_q != S_FINISH) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						temp_q <= sample.sample_temp;
						if (over_crit) begin
							pend_cls_q  <= CLS_ERROR;
							pend_rate_q <= '0;
							state_q     <= S_FINISH;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (hist_done) begin
						state_q <= S_RATE;
					end
				end
				S_RATE: begin
					if (rate_done) begin
						pend_cls_q  <= rate_warn ? CLS_WARN : CLS_NONE;
						pend_rate_q <= rate_val;
						state_q     <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_cls_q   <= pend_cls_q;
						out_rate_q  <= pend_rate_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	tta_history #(
		.DEPTH(HISTORY_DEPTH)
	) u_history (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (hist_req),
		.ignore_sec(ignore_q),
		.span_sec  ({1'b0, window_q} + {1'b0, ignore_q}),
		.done      (hist_done),
		.sum       (hist_sum),
		.count     (hist_count)
	);

	tta_rate #(
		.CNT_W(CNT_W)
	) u_rate (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (rate_start),
		.cur       (temp_q),
		.sum       (hist_sum),
		.n         (hist_count),
		.window_sec(window_q),
		.rise_limit(rise_q),
		.done      (rate_done),
		.warn      (rate_warn),
		.rate      (rate_val)
	);

	assign result.valid         = out_valid_q;
	assign result.anomaly_class = out_cls_q;
	assign result.rise_rate     = out_rate_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tta_history.sv =====
// Sample history ring of the temperature trend alarm: one synchronous memory,
// write pointer, fill count and the newest-to-oldest scan that sums the window.
// Depends on tta_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tta_history import tta_pkg::*; #(
	parameter int DEPTH = DEPTH_DEFAULT,
	localparam int SLOT_W = $clog2(DEPTH),
	localparam int CNT_W  = $clog2(DEPTH + 1),
	localparam int SUM_W  = TEMP_W + CNT_W
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire hist_req_t               req,
	input  wire logic [SEC_W-1:0]        ignore_sec,
	input  wire logic [SEC_W:0]          span_sec,
	output logic                         done,
	output logic signed [SUM_W-1:0]      sum,
	output logic [CNT_W-1:0]             count
);

	localparam int ENTRY_W = TIME_W + TEMP_W;
	localparam int CMP_W   = TIME_W + 2;

	logic [ENTRY_W-1:0] mem [DEPTH];

	logic [SLOT_W-1:0]        slot_q;
	logic [CNT_W-1:0]         stored_q;
	logic [TIME_W-1:0]        now_q;
	logic [SLOT_W-1:0]        rd_idx_q;
	logic [CNT_W-1:0]         issued_q;
	logic                     issuing_q;
	logic [ENTRY_W-1:0]       rd_data_s1;
	logic                     valid_s1;
	logic                     last_s1;
	logic                     stop_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]         n_q;
	logic                     done_q;

	logic                     issue_last;
	logic [TIME_W-1:0]        t_s1;
	logic signed [TEMP_W-1:0] temp_s1;
	logic                     too_new_s1;
	logic                     too_old_s1;

	assign issue_last = (issued_q + 1'b1) == stored_q;
	assign t_s1       = rd_data_s1[ENTRY_W-1 -: TIME_W];
	assign temp_s1    = $signed(rd_data_s1[TEMP_W-1:0]);
	assign too_new_s1 = (CMP_W'(t_s1) + CMP_W'(ignore_sec)) > CMP_W'(now_q);
	assign too_old_s1 = (CMP_W'(t_s1) + CMP_W'(span_sec)) <= CMP_W'(now_q);

	// Ring storage: the new sample goes in on the accepting edge, and the scan
	// issues its first read in the following cycle, so it always sees that sample.
	always_ff @(posedge clk) begin
		if (req.start) begin
			mem[slot_q] <= {req.now, req.temp};
		end
		if (issuing_q) begin
			rd_data_s1 <= mem[rd_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q    <= '0;
			stored_q  <= '0;
			now_q     <= '0;
			rd_idx_q  <= '0;
			issued_q  <= '0;
			issuing_q <= 1'b0;
			valid_s1  <= 1'b0;
			last_s1   <= 1'b0;
			stop_q    <= 1'b0;
			sum_q     <= '0;
			n_q       <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q   <= valid_s1 && last_s1;
			valid_s1 <= issuing_q;
			last_s1  <= issuing_q && issue_last;

			if (req.start) begin
				now_q     <= req.now;
				slot_q    <= (slot_q == SLOT_W'(DEPTH - 1)) ? '0 : slot_q + 1'b1;
				if (stored_q != CNT_W'(DEPTH)) begin
					stored_q <= stored_q + 1'b1;
				end
				rd_idx_q  <= slot_q;
				issued_q  <= '0;
				issuing_q <= req.scan;
				stop_q    <= 1'b0;
				sum_q     <= '0;
				n_q       <= '0;
			end else if (issuing_q) begin
				rd_idx_q  <= (rd_idx_q == '0) ? SLOT_W'(DEPTH - 1) : rd_idx_q - 1'b1;
				issued_q  <= issued_q + 1'b1;
				issuing_q <= !issue_last;
			end

			// Once an entry at or before the window start is seen, the rest of the
			// ring is ignored.
			if (valid_s1 && !stop_q && !too_new_s1) begin
				if (too_old_s1) begin
					stop_q <= 1'b1;
				end else begin
					sum_q <= sum_q + SUM_W'(temp_s1);
					n_q   <= n_q + 1'b1;
				end
			end
		end
	end

	assign done  = done_q;
	assign sum   = sum_q;
	assign count = n_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tta_rate.sv =====
// Rise rate unit of the temperature trend alarm: forms (cur*n - sum)*60 and n*window,
// decides the warning exactly and divides by restoring steps, one quotient bit a cycle.
// Depends on tta_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tta_rate import tta_pkg::*; #(
	parameter int CNT_W = 7,
	localparam int SUM_W = TEMP_W + CNT_W
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic signed [TEMP_W-1:0] cur,
	input  wire logic signed [SUM_W-1:0]  sum,
	input  wire logic [CNT_W-1:0]         n,
	input  wire logic [SEC_W-1:0]         window_sec,
	input  wire logic [RL_W-1:0]          rise_limit,
	output logic                          done,
	output logic                          warn,
	output logic signed [RATE_W-1:0]      rate
);

	localparam int P1_W   = SUM_W + 1;
	localparam int NUM_W  = P1_W + 6;
	localparam int DEN_W  = SEC_W + CNT_W;
	localparam int LIM_W  = RL_W + DEN_W;
	localparam int CMPW   = LIM_W + 1;
	localparam int DIV_W  = DEN_W + Q_W;
	localparam int STEP_W = $clog2(Q_W);

	typedef enum logic [2:0] {
		R_IDLE,
		R_NUM,
		R_LIM,
		R_PREP,
		R_DIV,
		R_OUT
	} rate_state_t;

	rate_state_t             state_q;
	logic signed [P1_W-1:0]  p1_q;
	logic [DEN_W-1:0]        den_q;
	logic                    zero_q;
	logic signed [NUM_W-1:0] num_q;
	logic [LIM_W-1:0]        lim_q;
	logic [NUM_W-1:0]        mag_q;
	logic                    neg_q;
	logic                    ovf_q;
	logic [DIV_W-1:0]        rem_q;
	logic [DIV_W-1:0]        dsh_q;
	logic [Q_W-1:0]          quo_q;
	logic [STEP_W-1:0]       step_q;
	logic                    done_q;
	logic                    warn_q;
	logic signed [RATE_W-1:0] rate_q;

	logic signed [P1_W-1:0]  cur_w;
	logic signed [P1_W-1:0]  n_w;
	logic [DEN_W-1:0]        n_d;
	logic [DEN_W-1:0]        w_d;
	logic signed [NUM_W-1:0] diff_w;
	logic [LIM_W-1:0]        rl_l;
	logic [LIM_W-1:0]        den_l;
	logic signed [CMPW-1:0]  num_c;
	logic signed [CMPW-1:0]  lim_c;
	logic                    sat;
	logic [RATE_W-1:0]       mag_r;

	assign cur_w  = P1_W'(cur);
	assign n_w    = $signed({{(P1_W - CNT_W){1'b0}}, n});
	assign n_d    = DEN_W'(n);
	// A zero window divides as a window of one.
	assign w_d    = (window_sec == '0) ? DEN_W'(1) : DEN_W'(window_sec);
	assign diff_w = NUM_W'(p1_q - P1_W'(sum));
	assign rl_l   = LIM_W'(rise_limit);
	assign den_l  = LIM_W'(den_q);
	assign num_c  = CMPW'(num_q);
	assign lim_c  = $signed({1'b0, lim_q});
	assign sat    = ovf_q || (quo_q == Q_W'(RATE_MAX + 1));
	assign mag_r  = sat ? RATE_W'(RATE_MAX) : RATE_W'(quo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			done_q  <= 1'b0;
			warn_q  <= 1'b0;
			rate_q  <= '0;
			step_q  <= '0;
		end else begin
			done_q <= (state_q == R_OUT);
			unique case (state_q)
				R_IDLE: begin
					if (start) begin
						p1_q    <= cur_w * n_w;
						den_q   <= n_d * w_d;
						zero_q  <= (n == '0);
						state_q <= R_NUM;
					end
				end
				R_NUM: begin
					num_q   <= (diff_w <<< 6) - (diff_w <<< 2);
					state_q <= R_LIM;
				end
				R_LIM: begin
					lim_q   <= rl_l * den_l;
					neg_q   <= num_q[NUM_W-1];
					mag_q   <= num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);
					state_q <= R_PREP;
				end
				R_PREP: begin
					// With no qualifying sample the rate is zero, so only a zero limit warns.
					warn_q  <= zero_q ? (rise_limit == '0) : (num_c >= lim_c);
					ovf_q   <= DIV_W'(mag_q) >= (DIV_W'(den_q) << Q_W);
					rem_q   <= DIV_W'(mag_q);
					dsh_q   <= DIV_W'(den_q) << (Q_W - 1);
					quo_q   <= '0;
					step_q  <= STEP_W'(Q_W - 1);
					state_q <= R_DIV;
				end
				R_DIV: begin
					if (rem_q >= dsh_q) begin
						rem_q <= rem_q - dsh_q;
						quo_q <= {quo_q[Q_W-2:0], 1'b1};
					end else begin
						quo_q <= {quo_q[Q_W-2:0], 1'b0};
					end
					dsh_q <= dsh_q >> 1;
					if (step_q == '0) begin
						state_q <= R_OUT;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				R_OUT: begin
					if (zero_q) begin
						rate_q <= '0;
					end else begin
						rate_q <= neg_q ? $signed(-mag_r) : $signed(mag_r);
					end
					state_q <= R_IDLE;
				end
				default: begin
					state_q <= R_IDLE;
				end
			endcase
		end
	end

	assign done = done_q;
	assign warn = warn_q;
	assign rate = rate_q;

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for the temperature trend alarm: directed cases, then phases of
// random sample streams under changing thresholds, with result expectations predicted.
// Depends on tta_pkg, tta_if and temperature_trend_alarm.
`timescale 1ns / 1ps

module tb_top;
	import tta_pkg::*;

	localparam int RING_DEPTH = DEPTH_DEFAULT;
	localparam int TREND_PHASES = 12;
	localparam int PHASE_SAMPLES = 75;

	typedef struct packed {
		logic [CLS_W-1:0]         cls;
		logic signed [RATE_W-1:0] rate;
	} alarm_t;

	logic clk;
	logic arst_n;

	tta_cfg_if    cfg_ch ();
	tta_sample_if smp_ch ();
	tta_result_if res_ch ();

	temperature_trend_alarm #(
		.HISTORY_DEPTH(RING_DEPTH)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.sample (smp_ch),
		.result (res_ch)
	);

	// Predicted copy of the block: sample history and thresholds.
	logic [TIME_W-1:0]        ring_time [RING_DEPTH];
	logic signed [TEMP_W-1:0] ring_temp [RING_DEPTH];
	int                       ring_slot = 0;
	int                       ring_fill = 0;
	logic signed [TEMP_W-1:0] crit_lvl = CRIT_RESET;
	logic [RL_W-1:0]          rise_lim = RL_RESET;
	logic [SEC_W-1:0]         win_sec  = WINDOW_RESET;
	logic [SEC_W-1:0]         ign_sec  = IGNORE_RESET;

	alarm_t alarm_q [$];

	int  mismatches = 0;
	int  samples_sent = 0;
	int  results_seen = 0;
	int  reg_writes = 0;
	int  warn_seen = 0;
	int  error_seen = 0;
	bit  gaps_on = 1'b1;
	bit  stalls_on = 1'b1;

	logic [TIME_W-1:0] cur_time = '0;
	int                walk_temp = 0;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic alarm_t predict_trend(input logic [TIME_W-1:0] now,
			input logic signed [TEMP_W-1:0] cur);
		alarm_t res;
		longint skip_after, stop_at, stamp, total, cnt, num, den, rate;
		int     idx;
		bit     stopped;
		idx = ring_slot;
		ring_time[idx] = now;
		ring_temp[idx] = cur;
		ring_slot = (ring_slot == RING_DEPTH - 1) ? 0 : ring_slot + 1;
		if (ring_fill < RING_DEPTH)
			ring_fill++;
		res.cls = CLS_NONE;
		res.rate = '0;
		if (cur > crit_lvl) begin
			res.cls = CLS_ERROR;
			return res;
		end
		skip_after = longint'(now) - longint'(ign_sec);
		stop_at = skip_after - longint'(win_sec);
		total = 0;
		cnt = 0;
		stopped = 1'b0;
		// Newest first in ring order; the stop bound never exceeds the skip bound.
		for (int k = 0; k < ring_fill && !stopped; k++) begin
			stamp = longint'(ring_time[idx]);
			if (stamp <= stop_at) begin
				stopped = 1'b1;
			end else if (stamp <= skip_after) begin
				total += ring_temp[idx];
				cnt++;
			end
			idx = (idx == 0) ? RING_DEPTH - 1 : idx - 1;
		end
		if (cnt == 0) begin
			if (rise_lim == 0)
				res.cls = CLS_WARN;
		end else begin
			den = cnt * ((win_sec == 0) ? 1 : longint'(win_sec));
			num = (longint'(cur) * cnt - total) * 60;
			if (num >= longint'(rise_lim) * den)
				res.cls = CLS_WARN;
			rate = num / den;
			if (rate > RATE_MAX)
				rate = RATE_MAX;
			if (rate < -RATE_MAX)
				rate = -RATE_MAX;
			res.rate = rate[RATE_W-1:0];
		end
		return res;
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_CRITICAL: crit_lvl = val[TEMP_W-1:0];
			REG_RISE:     rise_lim = val[RL_W-1:0];
			REG_WINDOW:   win_sec = val[SEC_W-1:0];
			REG_IGNORE:   ign_sec = val[SEC_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic logic signed [TEMP_W-1:0] clamp_temp(input int v);
		if (v > 2047)
			return 12'sd2047;
		if (v < -2048)
			return -12'sd2048;
		return v[TEMP_W-1:0];
	endfunction

	// Valid stays high after a transfer until a gap in a later call or a release.
	task automatic send_sample(input logic [TIME_W-1:0] stamp,
			input logic signed [TEMP_W-1:0] temp);
		alarm_t want;
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			smp_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		smp_ch.valid <= 1'b1;
		smp_ch.sample_time <= stamp;
		smp_ch.sample_temp <= temp;
		@(posedge clk);
		while (!smp_ch.ready)
			@(posedge clk);
		want = predict_trend(stamp, temp);
		alarm_q.push_back(want);
		samples_sent++;
		if (want.cls == CLS_WARN)
			warn_seen++;
		if (want.cls == CLS_ERROR)
			error_seen++;
	endtask

	task automatic drain_samples();
		smp_ch.valid <= 1'b0;
		while (alarm_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		apply_reg(idx, val);
		reg_writes++;
	endtask

	// Registers change only once every pending result has come back.
	task automatic program_regs(input logic [CFG_DATA_W-1:0] crit_d, rise_d, win_d, ign_d,
			input bit stray);
		drain_samples();
		write_reg(REG_CRITICAL, crit_d);
		write_reg(REG_RISE, rise_d);
		write_reg(REG_WINDOW, win_d);
		write_reg(REG_IGNORE, ign_d);
		if (stray)
			write_reg(CFG_IDX_W'(REG_IGNORE + $urandom_range(1, 12)), CFG_DATA_W'($urandom));
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic test_defaults();
		send_sample(32'd0, 12'sd0);
		send_sample(32'd20, 12'sd160);
		send_sample(32'd21, 12'sd433);
		send_sample(32'd22, 12'sd432);
		send_sample(32'd40, 12'sd2047);
		send_sample(32'd41, -12'sd2048);
		send_sample(32'hFFFF_FFFF, 12'sd100);
	endtask

	task automatic test_out_of_order();
		send_sample(32'd1000, 12'sd50);
		send_sample(32'd1015, 12'sd60);
		send_sample(32'd990, 12'sd70);
		send_sample(32'd1020, 12'sd80);
	endtask

	task automatic test_limit_extremes();
		// Lowest threshold, zero rise limit, zero window and zero ignore time.
		program_regs(16'h0800, 16'h0000, 16'h0000, 16'h0000, 1'b0);
		send_sample(32'd2000, -12'sd2048);
		send_sample(32'd2000, -12'sd2048);
		send_sample(32'd2001, -12'sd2047);
		// Widest spans and the largest rise limit.
		program_regs(16'h07FF, 16'h1FFF, 16'h0FFF, 16'h0FFF, 1'b0);
		send_sample(32'd10000, 12'sd2047);
		send_sample(32'd14000, -12'sd2048);
		send_sample(32'd14096, 12'sd2047);
		// One second windows drive the rate into saturation both ways.
		program_regs(16'h07FF, 16'h1FFF, 16'h0001, 16'h0001, 1'b0);
		send_sample(32'd20000, -12'sd2048);
		send_sample(32'd20001, 12'sd2047);
		send_sample(32'd20002, -12'sd2048);
	endtask

	task automatic test_register_masking();
		// Upper data bits must be dropped; unused indexes must not disturb anything.
		program_regs(16'hF1B0, 16'hE030, 16'hF01E, 16'hF00A, 1'b1);
		@(posedge clk);
		write_reg(CFG_IDX_W'(REG_IGNORE + 1), 16'hFFFF);
		write_reg(CFG_IDX_W'(REG_IGNORE + 12), 16'h0000);
		cfg_ch.valid <= 1'b0;
		send_sample(32'd30000, 12'sd300);
		send_sample(32'd30012, 12'sd340);
	endtask

	task automatic run_trend_phase(input int kind, input int count);
		logic [TEMP_W-1:0] crit_v;
		logic [RL_W-1:0]   rise_v;
		logic [SEC_W-1:0]  win_v, ign_v;
		int                roll;
		case (kind)
			0: begin
				crit_v = TEMP_W'($urandom_range(300, 600));
				rise_v = RL_W'($urandom_range(0, 120));
				win_v = SEC_W'($urandom_range(5, 60));
				ign_v = SEC_W'($urandom_range(0, 15));
			end
			1: begin
				// Long window with steady timestamps: the scan wraps the whole ring.
				crit_v = TEMP_W'($urandom_range(400, 2047));
				rise_v = RL_W'($urandom_range(0, 20));
				win_v = SEC_W'($urandom_range(3000, 4095));
				ign_v = SEC_W'($urandom_range(0, 3));
			end
			2: begin
				crit_v = TEMP_W'($urandom);
				rise_v = RL_W'($urandom);
				win_v = SEC_W'($urandom_range(0, 2));
				ign_v = SEC_W'($urandom_range(0, 2));
			end
			3: begin
				crit_v = TEMP_W'($urandom);
				rise_v = RL_W'($urandom);
				win_v = SEC_W'($urandom);
				ign_v = SEC_W'($urandom);
			end
			default: begin
				crit_v = TEMP_W'($urandom_range(350, 500));
				rise_v = ($urandom_range(0, 1) != 0) ? RL_W'(0) : RL_W'($urandom_range(0, 80));
				win_v = SEC_W'($urandom_range(1, 40));
				ign_v = SEC_W'($urandom_range(0, 10));
			end
		endcase
		program_regs({4'($urandom), crit_v}, {3'($urandom), rise_v}, {4'($urandom), win_v},
			{4'($urandom), ign_v}, $urandom_range(0, 3) == 0);
		if (kind == 3)
			cur_time = TIME_W'($urandom);
		else if (kind == 2 && $urandom_range(0, 1) != 0)
			cur_time = 32'hFFFF_FFFF - TIME_W'($urandom_range(0, 100));
		else
			cur_time += TIME_W'($urandom_range(100, 5000));
		walk_temp = int'(crit_lvl) - int'($urandom_range(0, 120));
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 85) begin
				cur_time += TIME_W'($urandom_range(0, 3));
				walk_temp += int'($urandom_range(0, 40)) - 20;
				if (roll < 2)
					walk_temp += 250;
				else if (roll < 4)
					walk_temp -= 250;
			end else if (roll < 93) begin
				cur_time -= TIME_W'($urandom_range(1, 60));
			end else begin
				cur_time = TIME_W'($urandom);
				walk_temp = int'($urandom_range(0, 4095)) - 2048;
			end
			walk_temp = clamp_temp(walk_temp);
			send_sample(cur_time, clamp_temp(walk_temp));
		end
	endtask

	task automatic test_random_trends();
		for (int p = 0; p < TREND_PHASES; p++) begin
			if (p >= TREND_PHASES - 3) begin
				gaps_on = 1'b0;
				stalls_on = 1'b0;
			end else begin
				gaps_on = (p % 4 != 2);
				stalls_on = (p % 4 != 3);
			end
			run_trend_phase((p < 4) ? p : $urandom_range(0, 4), PHASE_SAMPLES);
		end
	endtask

	initial begin : result_checker
		int     stall_left;
		alarm_t want;
		stall_left = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (res_ch.valid && res_ch.ready) begin
					results_seen++;
					if (alarm_q.size() == 0) begin
						mismatches++;
						if (mismatches <= 10)
							$display("unexpected result: class %0d rate %0d",
								res_ch.anomaly_class, res_ch.rise_rate);
					end else begin
						want = alarm_q.pop_front();
						if (res_ch.anomaly_class !== want.cls || res_ch.rise_rate !== want.rate) begin
							mismatches++;
							if (mismatches <= 10)
								$display("result %0d: class exp %0d got %0d, rate exp %0d got %0d",
									results_seen, want.cls, res_ch.anomaly_class,
									want.rate, res_ch.rise_rate);
						end
					end
				end
				if (stall_left > 0) begin
					stall_left--;
					res_ch.ready <= 1'b0;
				end else if (stalls_on && $urandom_range(0, 5) == 0) begin
					stall_left = $urandom_range(0, 4);
					res_ch.ready <= 1'b0;
				end else begin
					res_ch.ready <= 1'b1;
				end
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= '0;
		cfg_ch.data <= '0;
		smp_ch.valid <= 1'b0;
		smp_ch.sample_time <= '0;
		smp_ch.sample_temp <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_defaults();
		test_out_of_order();
		test_limit_extremes();
		test_register_masking();
		test_random_trends();

		drain_samples();
		repeat (100) @(posedge clk);
		if (alarm_q.size() != 0) begin
			mismatches += alarm_q.size();
			$display("%0d results never arrived", alarm_q.size());
		end

		$display("Sent %0d samples, %0d register writes, %0d results checked.",
			samples_sent, reg_writes, results_seen);
		$display("Predicted %0d warnings and %0d over-critical errors.", warn_seen, error_seen);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#15_000_000;
		$display("timeout with %0d results pending", alarm_q.size());
		$display("DONE: errors detected");
		$finish;
	end

endmodule
